[rtl/ecgs_pkg.sv]
`timescale 1ns / 1ps

package ecgs_pkg;

	// Field widths of the configuration port, the command beat and the result beat.
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CMD_W     = 1;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 6;
	localparam int RND_W     = 16;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 13;
	localparam int EDGE_W    = 15;
	localparam int SUM_W     = 18;

	// Cell weight storage and the running weight of the random walk.
	localparam int WT_W  = 4;
	localparam int RUN_W = RND_W + 1;

	localparam logic [WT_W-1:0] OCCUPIED_MARK = 4'd9;
	localparam logic [WT_W-1:0] WEIGHT_CAP    = 4'd8;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PLACE  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_RANDOM = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_CELL  = 2'd1,
		STATUS_RANGE    = 2'd2,
		STATUS_OFF_GRID = 2'd3
	} status_t;

	// Neighbor visiting order of an occupy operation.
	typedef enum logic [1:0] {
		NB_UP    = 2'd0,
		NB_LEFT  = 2'd1,
		NB_DOWN  = 2'd2,
		NB_RIGHT = 2'd3
	} nb_dir_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_TGT_RD,
		ST_TGT_WR,
		ST_NB_RD,
		ST_NB_WR,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic capture;
		logic check;
		logic walk_start;
		logic walk_step;
		logic walk_fail;
		logic tgt_rd;
		logic tgt_wr;
		logic nb_rd;
		logic nb_wr;
		logic nb_next;
		logic resp_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic is_random;
		logic edge_zero;
		logic rnd_big;
		logic off_grid;
		logic walk_found;
		logic walk_end;
		logic nb_ok;
		logic nb_last;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/ecgs_if.sv]
`timescale 1ns / 1ps

// Command channel: one beat per growth step.
interface ecgs_req_if;
	logic                           valid;
	logic                           ready;
	logic [ecgs_pkg::CMD_W-1:0]     cmd;
	logic [ecgs_pkg::ROW_W-1:0]     row;
	logic [ecgs_pkg::COL_W-1:0]     col;
	logic [ecgs_pkg::RND_W-1:0]     random_value;

	modport source (output valid, cmd, row, col, random_value, input ready);
	modport sink (input valid, cmd, row, col, random_value, output ready);
endinterface

// Result channel: one beat per growth step.
interface ecgs_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ecgs_pkg::STATUS_W-1:0]  status;
	logic [ecgs_pkg::ROW_W-1:0]     placed_row;
	logic [ecgs_pkg::COL_W-1:0]     placed_col;
	logic [ecgs_pkg::OCC_W-1:0]     occupied_count;
	logic [ecgs_pkg::EDGE_W-1:0]    free_edge_total;
	logic [ecgs_pkg::SUM_W-1:0]     row_sum;
	logic [ecgs_pkg::SUM_W-1:0]     col_sum;

	modport source (output valid, status, placed_row, placed_col, occupied_count,
		free_edge_total, row_sum, col_sum, input ready);
	modport sink (input valid, status, placed_row, placed_col, occupied_count,
		free_edge_total, row_sum, col_sum, output ready);
endinterface

[rtl/ecgs_ctrl.sv]
`timescale 1ns / 1ps

module ecgs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 in_valid,
	output logic                 in_ready,
	output ecgs_pkg::ctrl_cmd_t  cmd,
	input  ecgs_pkg::dp_stat_t   stat
);

	ecgs_pkg::state_t state_q;
	ecgs_pkg::state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecgs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state. A register write always restarts the clearing pass.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ecgs_pkg::ST_CLEAR: begin
				if (stat.clr_done) state_nxt = ecgs_pkg::ST_IDLE;
			end
			ecgs_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = ecgs_pkg::ST_CHECK;
			end
			ecgs_pkg::ST_CHECK: begin
				if (stat.is_random) begin
					if (stat.edge_zero || stat.rnd_big) state_nxt = ecgs_pkg::ST_RESP;
					else state_nxt = ecgs_pkg::ST_WALK;
				end else begin
					if (stat.off_grid) state_nxt = ecgs_pkg::ST_RESP;
					else state_nxt = ecgs_pkg::ST_TGT_RD;
				end
			end
			ecgs_pkg::ST_WALK: begin
				if (stat.walk_found) state_nxt = ecgs_pkg::ST_TGT_RD;
				else if (stat.walk_end) state_nxt = ecgs_pkg::ST_RESP;
			end
			ecgs_pkg::ST_TGT_RD: begin
				state_nxt = ecgs_pkg::ST_TGT_WR;
			end
			ecgs_pkg::ST_TGT_WR: begin
				state_nxt = ecgs_pkg::ST_NB_RD;
			end
			ecgs_pkg::ST_NB_RD: begin
				if (stat.nb_ok) state_nxt = ecgs_pkg::ST_NB_WR;
				else if (stat.nb_last) state_nxt = ecgs_pkg::ST_RESP;
			end
			ecgs_pkg::ST_NB_WR: begin
				if (stat.nb_last) state_nxt = ecgs_pkg::ST_RESP;
				else state_nxt = ecgs_pkg::ST_NB_RD;
			end
			ecgs_pkg::ST_RESP: begin
				if (stat.out_free) state_nxt = ecgs_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = ecgs_pkg::ST_CLEAR;
			end
		endcase
		if (cfg_we) state_nxt = ecgs_pkg::ST_CLEAR;
	end

	// Commands to the datapath.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ecgs_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ecgs_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ecgs_pkg::ST_CHECK: begin
				cmd.check      = 1'b1;
				cmd.walk_start = stat.is_random && !stat.edge_zero && !stat.rnd_big;
			end
			ecgs_pkg::ST_WALK: begin
				cmd.walk_step = 1'b1;
				cmd.walk_fail = !stat.walk_found && stat.walk_end;
			end
			ecgs_pkg::ST_TGT_RD: begin
				cmd.tgt_rd = 1'b1;
			end
			ecgs_pkg::ST_TGT_WR: begin
				cmd.tgt_wr = 1'b1;
			end
			ecgs_pkg::ST_NB_RD: begin
				cmd.nb_rd   = stat.nb_ok;
				cmd.nb_next = !stat.nb_ok && !stat.nb_last;
			end
			ecgs_pkg::ST_NB_WR: begin
				cmd.nb_wr   = 1'b1;
				cmd.nb_next = !stat.nb_last;
			end
			ecgs_pkg::ST_RESP: begin
				cmd.resp_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/ecgs_datapath.sv]
`timescale 1ns / 1ps

module ecgs_datapath #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ecgs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ecgs_pkg::CFG_W-1:0]       cfg_data,
	input  logic [ecgs_pkg::CMD_W-1:0]       in_cmd,
	input  logic [ecgs_pkg::ROW_W-1:0]       in_row,
	input  logic [ecgs_pkg::COL_W-1:0]       in_col,
	input  logic [ecgs_pkg::RND_W-1:0]       in_rnd,
	input  ecgs_pkg::ctrl_cmd_t              cmd,
	output ecgs_pkg::dp_stat_t               stat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ecgs_pkg::STATUS_W-1:0]    out_status,
	output logic [ecgs_pkg::ROW_W-1:0]       out_placed_row,
	output logic [ecgs_pkg::COL_W-1:0]       out_placed_col,
	output logic [ecgs_pkg::OCC_W-1:0]       out_occupied_count,
	output logic [ecgs_pkg::EDGE_W-1:0]      out_free_edge_total,
	output logic [ecgs_pkg::SUM_W-1:0]       out_row_sum,
	output logic [ecgs_pkg::SUM_W-1:0]       out_col_sum
);

	localparam int RB       = $clog2(MAX_ROWS);
	localparam int CB       = $clog2(MAX_COLS);
	localparam int AW       = RB + CB;
	localparam int DEPTH    = MAX_ROWS * (2 ** CB);
	localparam int IW       = (RB > CB) ? RB + 1 : CB + 1;
	localparam int CW       = (IW > ecgs_pkg::CFG_W) ? IW : ecgs_pkg::CFG_W;
	localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
	localparam int COLS_RST = (MAX_COLS < 64) ? MAX_COLS : 64;

	localparam int WT_W = ecgs_pkg::WT_W;

	// A size of zero counts as one; a size above the lattice counts as the lattice.
	function automatic logic [ecgs_pkg::CFG_W-1:0] clamp_size(
		input logic [ecgs_pkg::CFG_W-1:0] v,
		input int maxv
	);
		logic [ecgs_pkg::CFG_W-1:0] r;
		r = v;
		if (v == '0) r = ecgs_pkg::CFG_W'(1);
		else if (int'(v) > maxv) r = ecgs_pkg::CFG_W'(maxv);
		return r;
	endfunction

	// Configuration and running totals.
	logic [ecgs_pkg::CFG_W-1:0]  rows_q, cols_q;
	logic [ecgs_pkg::OCC_W-1:0]  occ_q;
	logic [ecgs_pkg::EDGE_W-1:0] edge_q;
	logic [ecgs_pkg::SUM_W-1:0]  rsum_q, csum_q;

	// Cell weight memory.
	logic [WT_W-1:0] weight_q [DEPTH];
	logic [WT_W-1:0] rd_data_s1;
	logic            rd_en, wr_en;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic [WT_W-1:0] wr_data;
	logic [AW-1:0]   clr_q;

	// Captured command beat and the target cell.
	logic [ecgs_pkg::CMD_W-1:0] cmd_q;
	logic [ecgs_pkg::ROW_W-1:0] row_q;
	logic [ecgs_pkg::COL_W-1:0] col_q;
	logic [ecgs_pkg::RND_W-1:0] rnd_q;
	logic [RB-1:0]              tr_q;
	logic [CB-1:0]              tc_q;
	ecgs_pkg::status_t          status_q;
	ecgs_pkg::status_t          chk_status;
	ecgs_pkg::nb_dir_t          nb_q;

	// Walk scan state: read issue side and returned data side.
	logic [RB-1:0]                 wi_q, wrow_s1;
	logic [CB-1:0]                 wj_q, wcol_s1;
	logic                          wissue_q, wvld_s1;
	logic [ecgs_pkg::RUN_W-1:0]    run_q, run_next;
	logic                          wi_last, wj_last, walk_elig, walk_found;

	// Occupy helpers.
	logic [AW-1:0] tgt_addr, nb_addr;
	logic          nb_ok, tgt_new, bump_ok;

	// Output register.
	logic                          out_valid_q;
	ecgs_pkg::status_t             out_status_q;
	logic [ecgs_pkg::ROW_W-1:0]    out_row_q;
	logic [ecgs_pkg::COL_W-1:0]    out_col_q;
	logic [ecgs_pkg::OCC_W-1:0]    out_occ_q;
	logic [ecgs_pkg::EDGE_W-1:0]   out_edge_q;
	logic [ecgs_pkg::SUM_W-1:0]    out_rsum_q, out_csum_q;

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ecgs_pkg::CFG_W'(ROWS_RST);
			cols_q <= ecgs_pkg::CFG_W'(COLS_RST);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ecgs_pkg::REG_ROWS: rows_q <= clamp_size(cfg_data, MAX_ROWS);
				ecgs_pkg::REG_COLS: cols_q <= clamp_size(cfg_data, MAX_COLS);
			endcase
		end
	end

	// Capture of the command beat and the target cell.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_cmd;
			row_q <= in_row;
			col_q <= in_col;
			rnd_q <= in_rnd;
			tr_q  <= RB'(in_row);
			tc_q  <= CB'(in_col);
		end else if (cmd.walk_step && walk_found) begin
			tr_q <= wrow_s1;
			tc_q <= wcol_s1;
		end
	end

	// Early checks of a command.
	always_comb begin
		if (stat.is_random) begin
			if (stat.edge_zero) chk_status = ecgs_pkg::STATUS_NO_CELL;
			else if (stat.rnd_big) chk_status = ecgs_pkg::STATUS_RANGE;
			else chk_status = ecgs_pkg::STATUS_OK;
		end else begin
			if (stat.off_grid) chk_status = ecgs_pkg::STATUS_OFF_GRID;
			else chk_status = ecgs_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) status_q <= chk_status;
		else if (cmd.walk_fail) status_q <= ecgs_pkg::STATUS_NO_CELL;
	end

	// Walk: one read issued per cycle in row-major order, weights summed as they return.
	assign wj_last    = (CW'(wj_q) + CW'(1)) == CW'(cols_q);
	assign wi_last    = (CW'(wi_q) + CW'(1)) == CW'(rows_q);
	assign walk_elig  = wvld_s1 && (rd_data_s1 != '0) && (rd_data_s1 != ecgs_pkg::OCCUPIED_MARK);
	assign run_next   = run_q + ecgs_pkg::RUN_W'(rd_data_s1);
	assign walk_found = walk_elig && (run_next > ecgs_pkg::RUN_W'(rnd_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wissue_q <= 1'b0;
			wvld_s1  <= 1'b0;
		end else if (cmd.walk_start) begin
			wissue_q <= 1'b1;
			wvld_s1  <= 1'b0;
		end else if (cmd.walk_step) begin
			wvld_s1 <= wissue_q;
			if (wissue_q && wj_last && wi_last) wissue_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			wi_q  <= '0;
			wj_q  <= '0;
			run_q <= '0;
		end else if (cmd.walk_step) begin
			wrow_s1 <= wi_q;
			wcol_s1 <= wj_q;
			if (wissue_q) begin
				if (wj_last) begin
					wj_q <= '0;
					if (!wi_last) wi_q <= wi_q + RB'(1);
				end else begin
					wj_q <= wj_q + CB'(1);
				end
			end
			if (walk_elig) run_q <= run_next;
		end
	end

	// Neighbor selection around the target cell.
	assign tgt_addr = {tr_q, tc_q};

	always_comb begin
		nb_ok   = 1'b0;
		nb_addr = tgt_addr;
		case (nb_q)
			ecgs_pkg::NB_UP: begin
				nb_ok   = (tr_q != '0);
				nb_addr = {tr_q - RB'(1), tc_q};
			end
			ecgs_pkg::NB_LEFT: begin
				nb_ok   = (tc_q != '0);
				nb_addr = {tr_q, tc_q - CB'(1)};
			end
			ecgs_pkg::NB_DOWN: begin
				nb_ok   = (CW'(tr_q) + CW'(1)) < CW'(rows_q);
				nb_addr = {tr_q + RB'(1), tc_q};
			end
			ecgs_pkg::NB_RIGHT: begin
				nb_ok   = (CW'(tc_q) + CW'(1)) < CW'(cols_q);
				nb_addr = {tr_q, tc_q + CB'(1)};
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.tgt_wr) nb_q <= ecgs_pkg::NB_UP;
		else if (cmd.nb_next) nb_q <= ecgs_pkg::nb_dir_t'(nb_q + 2'd1);
	end

	assign tgt_new = (rd_data_s1 != ecgs_pkg::OCCUPIED_MARK);
	assign bump_ok = tgt_new && (rd_data_s1 < ecgs_pkg::WEIGHT_CAP);

	// Memory port selection.
	always_comb begin
		rd_en   = (cmd.walk_step && wissue_q) || cmd.tgt_rd || cmd.nb_rd;
		rd_addr = {wi_q, wj_q};
		if (cmd.tgt_rd) rd_addr = tgt_addr;
		else if (cmd.nb_rd) rd_addr = nb_addr;

		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.tgt_wr) begin
			wr_en   = tgt_new;
			wr_addr = tgt_addr;
			wr_data = ecgs_pkg::OCCUPIED_MARK;
		end else if (cmd.nb_wr) begin
			wr_en   = bump_ok;
			wr_addr = nb_addr;
			wr_data = rd_data_s1 + WT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) weight_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_s1 <= weight_q[rd_addr];
	end

	// Clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cfg_we) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Running totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			edge_q <= '0;
			rsum_q <= '0;
			csum_q <= '0;
		end else if (cfg_we) begin
			occ_q  <= '0;
			edge_q <= '0;
			rsum_q <= '0;
			csum_q <= '0;
		end else if (cmd.tgt_wr && tgt_new) begin
			occ_q  <= occ_q + ecgs_pkg::OCC_W'(1);
			edge_q <= edge_q - ecgs_pkg::EDGE_W'(rd_data_s1);
			rsum_q <= rsum_q + ecgs_pkg::SUM_W'(tr_q);
			csum_q <= csum_q + ecgs_pkg::SUM_W'(tc_q);
		end else if (cmd.nb_wr && bump_ok) begin
			edge_q <= edge_q + ecgs_pkg::EDGE_W'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			out_status_q <= status_q;
			out_row_q    <= (status_q == ecgs_pkg::STATUS_OK) ? ecgs_pkg::ROW_W'(tr_q) : '0;
			out_col_q    <= (status_q == ecgs_pkg::STATUS_OK) ? ecgs_pkg::COL_W'(tc_q) : '0;
			out_occ_q    <= occ_q;
			out_edge_q   <= edge_q;
			out_rsum_q   <= rsum_q;
			out_csum_q   <= csum_q;
		end
	end

	// Status back to the controller.
	always_comb begin
		stat.is_random  = (cmd_q == ecgs_pkg::CMD_RANDOM);
		stat.edge_zero  = (edge_q == '0);
		stat.rnd_big    = (rnd_q >= ecgs_pkg::RND_W'(edge_q));
		stat.off_grid   = ({1'b0, row_q} >= rows_q) || ({1'b0, col_q} >= cols_q);
		stat.clr_done   = (clr_q == AW'(DEPTH - 1));
		stat.walk_found = walk_found;
		stat.walk_end   = !wissue_q && !wvld_s1;
		stat.nb_ok      = nb_ok;
		stat.nb_last    = (nb_q == ecgs_pkg::NB_RIGHT);
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid           = out_valid_q;
	assign out_status          = out_status_q;
	assign out_placed_row      = out_row_q;
	assign out_placed_col      = out_col_q;
	assign out_occupied_count  = out_occ_q;
	assign out_free_edge_total = out_edge_q;
	assign out_row_sum         = out_rsum_q;
	assign out_col_sum         = out_csum_q;

endmodule

[rtl/eden_cluster_growth_step_core.sv]
`timescale 1ns / 1ps

// Eden cluster growth on a square lattice of up to MAX_ROWS by MAX_COLS cells, held as
// 4-bit weights in one single-port memory. A placement beat (cmd 0) runs a check, one
// read and write of the target cell, then a read and write for each in-grid neighbor
// and a skip step for each neighbor off the grid, then the result load. A random beat
// (cmd 1) first scans the in-use cells in row-major order, one memory read per cycle;
// the scan stops at the chosen cell. Error beats found by the check go straight to the
// result load. One beat is worked at a time; the result sits in an output register so
// the next beat is taken while it waits. After reset and after every register write, a
// clearing pass writes every one of the MAX_ROWS * 2**ceil(log2(MAX_COLS)) memory
// words (4096 by default), during which no beat is taken; register writes also reset
// all counts and sums.
module eden_cluster_growth_step_core #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ecgs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ecgs_pkg::CFG_W-1:0]      cfg_data,
	ecgs_req_if.sink                        req,
	ecgs_rsp_if.source                      rsp
);

	ecgs_pkg::ctrl_cmd_t cmd;
	ecgs_pkg::dp_stat_t  stat;

	ecgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	ecgs_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_idx             (cfg_idx),
		.cfg_data            (cfg_data),
		.in_cmd              (req.cmd),
		.in_row              (req.row),
		.in_col              (req.col),
		.in_rnd              (req.random_value),
		.cmd                 (cmd),
		.stat                (stat),
		.out_valid           (rsp.valid),
		.out_ready           (rsp.ready),
		.out_status          (rsp.status),
		.out_placed_row      (rsp.placed_row),
		.out_placed_col      (rsp.placed_col),
		.out_occupied_count  (rsp.occupied_count),
		.out_free_edge_total (rsp.free_edge_total),
		.out_row_sum         (rsp.row_sum),
		.out_col_sum         (rsp.col_sum)
	);

endmodule

[rtl/ecgs_checker.sv]
`timescale 1ns / 1ps

module ecgs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            req_valid,
	input  logic                            req_ready,
	input  logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  logic [ecgs_pkg::STATUS_W-1:0]   rsp_status,
	input  logic [ecgs_pkg::ROW_W-1:0]      rsp_placed_row,
	input  logic [ecgs_pkg::COL_W-1:0]      rsp_placed_col,
	input  logic [ecgs_pkg::OCC_W-1:0]      rsp_occupied_count,
	input  logic [ecgs_pkg::EDGE_W-1:0]     rsp_free_edge_total
);

	// Only one beat is worked at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command beat accepted while another is in work");

	// A register write starts the clearing pass, which holds off commands.
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req_ready)
		else $error("command channel open right after a register write");

	// A failed step reports no placed cell.
	a_error_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ecgs_pkg::STATUS_OK) |->
			(rsp_placed_row == '0) && (rsp_placed_col == '0))
		else $error("error result carries a placed cell");

	// A stalled result beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_occupied_count) && $stable(rsp_free_edge_total))
		else $error("stalled result beat changed");

endmodule

bind eden_cluster_growth_step_core ecgs_checker u_ecgs_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.cfg_we              (cfg_we),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_placed_row      (rsp.placed_row),
	.rsp_placed_col      (rsp.placed_col),
	.rsp_occupied_count  (rsp.occupied_count),
	.rsp_free_edge_total (rsp.free_edge_total)
);
